// ===== rtl/core/cqp_pkg.sv =====
package cqp_pkg;

  localparam int MAX_QUERY_LEN = 64;
  localparam int MAX_DIGITS    = 20;
  localparam int PREFIX_LEN    = 7;
  localparam int POS_W         = 7;
  localparam int DCNT_W        = 5;
  localparam int VAL_W         = 64;
  localparam int TOKQ_DEPTH    = 4;
  localparam int TOKQ_PTR_W    = $clog2(TOKQ_DEPTH);
  localparam int TOKQ_CNT_W    = $clog2(TOKQ_DEPTH + 1);

  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [7:0] CHAR_NINE = 8'h39;

  typedef struct packed {
    logic [7:0] char_code;
    logic       is_terminator;
  } in_req_t;

  typedef struct packed {
    logic             ok;
    logic [VAL_W-1:0] cursor_value;
  } out_req_t;

  typedef enum logic [1:0] {
    TOK_DIGIT,
    TOK_BAD,
    TOK_END
  } tok_kind_t;

  typedef struct packed {
    tok_kind_t  kind;
    logic [3:0] digit;
    logic       len_ok;
  } tok_t;

  typedef struct packed {
    logic valid;
    tok_t tok;
  } tok_wr_t;

  function automatic logic [7:0] prefix_char(input logic [2:0] idx);
    logic [7:0] c;
    unique case (idx)
      3'd0:    c = 8'h63;
      3'd1:    c = 8'h75;
      3'd2:    c = 8'h72;
      3'd3:    c = 8'h73;
      3'd4:    c = 8'h6f;
      3'd5:    c = 8'h72;
      3'd6:    c = 8'h3d;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

// ===== rtl/core/cqp_front.sv =====
module cqp_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  cqp_pkg::in_req_t  in_data,
  output logic              full,
  input  logic              tok_full,
  output cqp_pkg::tok_wr_t  tok_wr
);

  localparam logic [cqp_pkg::POS_W-1:0] MaxPos =
    cqp_pkg::POS_W'(cqp_pkg::MAX_QUERY_LEN);
  localparam logic [cqp_pkg::POS_W-1:0] PfxPos =
    cqp_pkg::POS_W'(cqp_pkg::PREFIX_LEN);

  logic [cqp_pkg::POS_W-1:0] pos_r, pos_nxt;
  logic                      pfx_fail_r, pfx_fail_nxt;
  logic                      accept;
  logic                      is_digit;

  assign full     = tok_full;
  assign accept   = push && !tok_full;
  assign is_digit = (in_data.char_code >= cqp_pkg::CHAR_ZERO) &&
                    (in_data.char_code <= cqp_pkg::CHAR_NINE);

  always_comb begin
    pos_nxt             = pos_r;
    pfx_fail_nxt        = pfx_fail_r;
    tok_wr.valid        = 1'b0;
    tok_wr.tok.kind     = cqp_pkg::TOK_BAD;
    tok_wr.tok.digit    = in_data.char_code[3:0];
    tok_wr.tok.len_ok   = !pfx_fail_r && (pos_r <= MaxPos) && (pos_r > PfxPos);
    if (accept) begin
      if (in_data.is_terminator) begin
        tok_wr.valid    = 1'b1;
        tok_wr.tok.kind = cqp_pkg::TOK_END;
        pos_nxt         = '0;
        pfx_fail_nxt    = 1'b0;
      end else if (pos_r <= MaxPos) begin
        pos_nxt = pos_r + 1'b1;
        if (pos_r < PfxPos) begin
          if (in_data.char_code != cqp_pkg::prefix_char(pos_r[2:0])) begin
            pfx_fail_nxt = 1'b1;
          end
        end else if (!pfx_fail_r) begin
          tok_wr.valid    = 1'b1;
          tok_wr.tok.kind = is_digit ? cqp_pkg::TOK_DIGIT : cqp_pkg::TOK_BAD;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r      <= '0;
      pfx_fail_r <= 1'b0;
    end else begin
      pos_r      <= pos_nxt;
      pfx_fail_r <= pfx_fail_nxt;
    end
  end

`ifndef SYNTHESIS
  a_pos_sat: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= MaxPos + 1'b1)
    else $error("position ran past saturation");
`endif

endmodule

// ===== rtl/core/cqp_tok_fifo.sv =====
module cqp_tok_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  cqp_pkg::tok_wr_t  wr,
  output logic              full,
  input  logic              rd_en,
  output cqp_pkg::tok_t     rd_tok,
  output logic              empty
);

  cqp_pkg::tok_t                   mem [cqp_pkg::TOKQ_DEPTH];
  logic [cqp_pkg::TOKQ_PTR_W-1:0]  wr_ptr_r, rd_ptr_r;
  logic [cqp_pkg::TOKQ_CNT_W-1:0]  cnt_r, cnt_nxt;
  logic                            do_wr, do_rd;

  assign full   = (cnt_r == cqp_pkg::TOKQ_CNT_W'(cqp_pkg::TOKQ_DEPTH));
  assign empty  = (cnt_r == '0);
  assign do_wr  = wr.valid && !full;
  assign do_rd  = rd_en && !empty;
  assign rd_tok = mem[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_wr && !do_rd) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr_r] <= wr.tok;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (do_wr) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_rd) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

endmodule

// ===== rtl/core/cqp_back.sv =====
module cqp_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              tok_empty,
  input  cqp_pkg::tok_t     tok,
  output logic              tok_take,
  input  logic              pop,
  output logic              empty,
  output cqp_pkg::out_req_t out_data
);

  localparam logic [cqp_pkg::DCNT_W-1:0] MaxDig =
    cqp_pkg::DCNT_W'(cqp_pkg::MAX_DIGITS);

  logic [cqp_pkg::VAL_W-1:0]  acc_r, acc_nxt;
  logic [cqp_pkg::DCNT_W-1:0] dcnt_r, dcnt_nxt;
  logic                       lz_r, lz_nxt;
  logic                       fail_r, fail_nxt;
  logic                       out_valid_r, out_valid_nxt;
  cqp_pkg::out_req_t          out_data_r, out_data_nxt;
  logic [cqp_pkg::VAL_W+3:0]  prod;
  logic                       dig_bad;
  logic                       res_ok;
  logic                       out_space;

  assign empty     = !out_valid_r;
  assign out_data  = out_data_r;
  assign out_space = !out_valid_r || pop;
  assign tok_take  = !tok_empty && ((tok.kind != cqp_pkg::TOK_END) || out_space);

  assign prod    = {1'b0, acc_r, 3'b000} + {3'b000, acc_r, 1'b0} +
                   {{cqp_pkg::VAL_W{1'b0}}, tok.digit};
  assign dig_bad = (dcnt_r >= MaxDig) || ((dcnt_r != '0) && lz_r) ||
                   (prod[cqp_pkg::VAL_W+3:cqp_pkg::VAL_W] != 4'd0);
  assign res_ok  = tok.len_ok && !fail_r && (dcnt_r != '0);

  always_comb begin
    acc_nxt       = acc_r;
    dcnt_nxt      = dcnt_r;
    lz_nxt        = lz_r;
    fail_nxt      = fail_r;
    out_valid_nxt = out_valid_r && !pop;
    out_data_nxt  = out_data_r;
    if (tok_take) begin
      unique case (tok.kind)
        cqp_pkg::TOK_DIGIT: begin
          if (!fail_r) begin
            if (dig_bad) begin
              fail_nxt = 1'b1;
            end else begin
              acc_nxt  = prod[cqp_pkg::VAL_W-1:0];
              dcnt_nxt = dcnt_r + 1'b1;
              if ((dcnt_r == '0) && (tok.digit == 4'd0)) begin
                lz_nxt = 1'b1;
              end
            end
          end
        end
        cqp_pkg::TOK_BAD: begin
          fail_nxt = 1'b1;
        end
        cqp_pkg::TOK_END: begin
          out_valid_nxt             = 1'b1;
          out_data_nxt.ok           = res_ok;
          out_data_nxt.cursor_value = res_ok ? acc_r : '0;
          acc_nxt                   = '0;
          dcnt_nxt                  = '0;
          lz_nxt                    = 1'b0;
          fail_nxt                  = 1'b0;
        end
        default: begin
          fail_nxt = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r       <= '0;
      dcnt_r      <= '0;
      lz_r        <= 1'b0;
      fail_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      acc_r       <= acc_nxt;
      dcnt_r      <= dcnt_nxt;
      lz_r        <= lz_nxt;
      fail_r      <= fail_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

`ifndef SYNTHESIS
  a_rej_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_data_r.ok |-> out_data_r.cursor_value == '0)
    else $error("rejected request carries a value");

  a_dcnt_max: assert property (@(posedge clk) disable iff (!rst_n)
    dcnt_r <= MaxDig)
    else $error("digit count beyond limit");

  a_lz_acc: assert property (@(posedge clk) disable iff (!rst_n)
    lz_r |-> (acc_r == '0) && (dcnt_r == 5'd1))
    else $error("leading zero with nonzero value");

  a_end_clear: assert property (@(posedge clk) disable iff (!rst_n)
    tok_take && (tok.kind == cqp_pkg::TOK_END) |=>
      (acc_r == '0) && (dcnt_r == '0) && !fail_r && !lz_r && out_valid_r)
    else $error("state not cleared after terminator");
`endif

endmodule

// ===== rtl/core/cursor_query_parser.sv =====
// cursor_query_parser: checks a query of the form "cursor=<decimal>".
// Input queue side: one byte per request on in_data.char_code; a request
// with in_data.is_terminator set ends the query. A request is taken at a
// clock edge with push high and full low.
// Result queue side: one request per terminator on out_data (ok and
// cursor_value, the value forced to 0 when ok is 0). It is valid while
// empty is low and is taken at an edge with pop high.
// Throughput: one input request per cycle, sustained, including
// terminators back to back while results are popped every cycle.
// Path: the result of a terminator passes the token queue write and then
// the result register load before it is visible on out_data.
// Stall: while pop is held low the result register holds; byte requests
// keep flowing into the 4-entry token queue and full rises once it fills.
// Reset (rst_n low at a clock edge): all queues empty, parse state
// cleared, full low and empty high.
module cursor_query_parser (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  cqp_pkg::in_req_t  in_data,
  output logic              full,
  output logic              empty,
  input  logic              pop,
  output cqp_pkg::out_req_t out_data
);

  cqp_pkg::tok_wr_t tok_wr;
  cqp_pkg::tok_t    tok_rd;
  logic             tok_full;
  logic             tok_empty;
  logic             tok_take;

  cqp_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .in_data  (in_data),
    .full     (full),
    .tok_full (tok_full),
    .tok_wr   (tok_wr)
  );

  cqp_tok_fifo u_tok_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr     (tok_wr),
    .full   (tok_full),
    .rd_en  (tok_take),
    .rd_tok (tok_rd),
    .empty  (tok_empty)
  );

  cqp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .tok_empty (tok_empty),
    .tok       (tok_rd),
    .tok_take  (tok_take),
    .pop       (pop),
    .empty     (empty),
    .out_data  (out_data)
  );

endmodule
